### rtl/wildcard_signature_scanner_core_macros.svh
// Assertion macros used by the scanner core RTL.
`ifndef WILDCARD_SIGNATURE_SCANNER_CORE_MACROS_SVH
`define WILDCARD_SIGNATURE_SCANNER_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define WSS_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("wss assertion failed");

// Next-cycle implication, checked out of reset.
`define WSS_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("wss assertion failed");

`endif

### rtl/wss_pkg.sv
// Package with types, constants and helpers of the signature scanner.
package wss_pkg;

	localparam int NUM_SIGS  = 64;
	localparam int PAT_BYTES = 32;
	localparam int SIG_W     = (NUM_SIGS > 1) ? $clog2(NUM_SIGS) : 1;
	localparam int IDX_W     = (PAT_BYTES > 1) ? $clog2(PAT_BYTES) : 1;
	localparam int LEN_W     = $clog2(PAT_BYTES + 1);
	localparam int HIST_W    = 8 * PAT_BYTES;

	localparam logic [1:0] FUNC_PAT  = 2'd0;
	localparam logic [1:0] FUNC_LEN  = 2'd1;
	localparam logic [1:0] FUNC_SCAN = 2'd2;

	localparam logic [7:0]  WILDCARD   = 8'h00;
	localparam logic [2:0]  THREAT_MIN = 3'd1;
	localparam logic [2:0]  THREAT_MAX = 3'd5;
	localparam logic [15:0] SCAN_SAT   = 16'hFFFF;
	localparam logic [19:0] HIT_SAT    = 20'hFFFFF;

	typedef struct packed {
		logic [1:0] func;
		logic [5:0] sig_index;
		logic [4:0] byte_index;
		logic [7:0] pattern_byte;
		logic [5:0] pattern_length;
		logic [3:0] threat;
		logic [7:0] data_byte;
		logic       data_valid;
		logic       last_byte;
	} req_t;

	typedef struct packed {
		logic [6:0]  match_count;
		logic [2:0]  buffer_threat;
		logic [2:0]  global_threat;
		logic [15:0] files_scanned;
		logic [19:0] threats_found;
	} rsp_t;

	// Broadcast control from the sequencer to every cell.
	typedef struct packed {
		logic             pat_we;
		logic [IDX_W-1:0] pat_idx;
		logic [7:0]       pat_byte;
		logic             len_we;
		logic [LEN_W-1:0] len;
		logic [2:0]       thr;
		logic             eval;
		logic [LEN_W-1:0] seen;
		logic             load;
		logic             shift;
	} cell_ctrl_t;

	// Hit flag and threat of one cell on its way down the result chain.
	typedef struct packed {
		logic       hit;
		logic [2:0] thr;
	} snap_t;

	function automatic logic [2:0] clamp_threat(input logic [3:0] t);
		logic [2:0] r;
		if (t > 4'(THREAT_MAX)) r = THREAT_MAX;
		else if (t < 4'(THREAT_MIN)) r = THREAT_MIN;
		else r = t[2:0];
		return r;
	endfunction

	function automatic logic [LEN_W-1:0] clamp_len(input logic [5:0] l);
		logic [LEN_W-1:0] r;
		if (32'(l) > PAT_BYTES) r = LEN_W'(PAT_BYTES);
		else r = LEN_W'(l);
		return r;
	endfunction

endpackage

### rtl/wss_cell.sv
// One signature cell: pattern, length, threat, hit flag and a result chain stage.
module wss_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  wss_pkg::cell_ctrl_t       ctrl,
	input  logic                      sel,
	input  logic [wss_pkg::HIST_W-1:0] hist_rev,
	input  wss_pkg::snap_t            snap_in,
	output wss_pkg::snap_t            snap_out
);
	import wss_pkg::*;

	localparam int SHW = $clog2(HIST_W + 1);

	logic [7:0]       pat_q [PAT_BYTES];
	logic [LEN_W-1:0] len_q;
	logic [2:0]       thr_q;
	logic             hit_q;
	snap_t            snap_q;

	logic [LEN_W-1:0]  gap;
	logic [SHW-1:0]    shamt;
	logic [HIST_W-1:0] aligned;
	logic [PAT_BYTES-1:0] ok;
	logic              hit_now;

	// Shifting the reversed history by the unused part of the pattern puts the
	// data byte that lines up with pattern byte j at byte j.
	assign gap     = LEN_W'(PAT_BYTES) - len_q;
	assign shamt   = SHW'({gap, 3'b000});
	assign aligned = hist_rev >> shamt;

	always_comb begin
		for (int j = 0; j < PAT_BYTES; j++) begin
			ok[j] = (LEN_W'(j) >= len_q) || (pat_q[j] == WILDCARD) ||
				(pat_q[j] == aligned[8*j +: 8]);
		end
	end

	assign hit_now = ctrl.eval && (len_q != '0) && (len_q <= ctrl.seen) && (&ok);

	always_ff @(posedge clk) begin
		if (sel && ctrl.pat_we) begin
			pat_q[ctrl.pat_idx] <= ctrl.pat_byte;
		end
		if (sel && ctrl.len_we) begin
			thr_q <= ctrl.thr;
		end
		if (ctrl.load) begin
			snap_q <= '{hit: hit_q | hit_now, thr: thr_q};
		end else if (ctrl.shift) begin
			snap_q <= snap_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			hit_q <= 1'b0;
		end else begin
			if (sel && ctrl.len_we) len_q <= ctrl.len;
			if (ctrl.load) hit_q <= 1'b0;
			else if (hit_now) hit_q <= 1'b1;
		end
	end

	assign snap_out = snap_q;

endmodule

### rtl/wildcard_signature_scanner_core.sv
// Top level of the wildcard signature scanner: sequencer, byte history and cell chain.
//
// The scanner keeps NUM_SIGS signatures of up to PAT_BYTES bytes in a row of
// cells, one signature per cell; a pattern byte of zero matches any data byte.
// Pattern writes and length/threat writes complete without leaving the idle state.
// A scan request with a real byte passes through the compare state: the byte
// enters the shared history, then every cell compares its signature against the
// history in parallel and sets its sticky hit flag. The request that ends a
// buffer additionally starts the result pass: each cell snapshots its hit flag
// and threat, and the snapshots shift down the cell chain into a counter at its
// tail, one cell per cycle. The new result waits until the previous result has
// been taken. The result stays in an output register until taken; requests are
// accepted only while the sequencer is idle.
module wildcard_signature_scanner_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            scan_valid,
	output logic            scan_ready,
	input  wss_pkg::req_t   scan_req,
	output logic            result_valid,
	input  logic            result_ready,
	output wss_pkg::rsp_t   result
);
	import wss_pkg::*;

	`include "wildcard_signature_scanner_core_macros.svh"

	typedef enum logic [1:0] {S_IDLE, S_EVAL, S_SUM, S_DONE} state_t;

	state_t            state_q;
	logic [HIST_W-1:0] hist_q;
	logic [LEN_W-1:0]  seen_q;
	logic              last_q;
	logic [SIG_W-1:0]  sum_cnt_q;
	logic [6:0]        cnt_q;
	logic [2:0]        best_q;
	logic [2:0]        global_q;
	logic [15:0]       files_q;
	logic [19:0]       hits_q;
	logic              result_valid_q;
	rsp_t              result_q;

	logic              accept;
	logic              load;
	cell_ctrl_t        ctrl;
	logic [HIST_W-1:0] hist_rev;
	snap_t             chain [NUM_SIGS + 1];

	logic [2:0]  global_next;
	logic [15:0] files_next;
	logic [20:0] hits_sum;
	logic [19:0] hits_next;

	assign scan_ready = (state_q == S_IDLE);
	assign accept     = scan_valid && scan_ready;

	// A buffer ends either after the compare of its last byte, or at once for
	// an end marker that carries no byte.
	assign load = (state_q == S_EVAL && last_q) ||
		(accept && scan_req.func == FUNC_SCAN && !scan_req.data_valid &&
		scan_req.last_byte);

	always_comb begin
		ctrl.pat_we   = accept && scan_req.func == FUNC_PAT &&
			32'(scan_req.byte_index) < PAT_BYTES;
		ctrl.pat_idx  = IDX_W'(scan_req.byte_index);
		ctrl.pat_byte = scan_req.pattern_byte;
		ctrl.len_we   = accept && scan_req.func == FUNC_LEN;
		ctrl.len      = clamp_len(scan_req.pattern_length);
		ctrl.thr      = clamp_threat(scan_req.threat);
		ctrl.eval     = (state_q == S_EVAL);
		ctrl.seen     = seen_q;
		ctrl.load     = load;
		ctrl.shift    = (state_q == S_SUM);
	end

	// Byte k of the history is the k-th newest; the cells want it reversed.
	always_comb begin
		for (int j = 0; j < PAT_BYTES; j++) begin
			hist_rev[8*j +: 8] = hist_q[8*(PAT_BYTES-1-j) +: 8];
		end
	end

	assign chain[0] = '0;

	for (genvar i = 0; i < NUM_SIGS; i++) begin : g_cell
		wss_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.sel      (32'(scan_req.sig_index) == i),
			.hist_rev (hist_rev),
			.snap_in  (chain[i]),
			.snap_out (chain[i+1])
		);
	end

	assign global_next = (best_q > global_q) ? best_q : global_q;
	assign files_next  = (files_q == SCAN_SAT) ? files_q : files_q + 16'd1;
	assign hits_sum    = {1'b0, hits_q} + 21'(cnt_q);
	assign hits_next   = hits_sum[20] ? HIT_SAT : hits_sum[19:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			hist_q         <= '0;
			seen_q         <= '0;
			last_q         <= 1'b0;
			sum_cnt_q      <= '0;
			cnt_q          <= '0;
			best_q         <= '0;
			global_q       <= '0;
			files_q        <= '0;
			hits_q         <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			// In the final state a taken result is replaced below by the new one.
			if (result_valid_q && result_ready && state_q != S_DONE) begin
				result_valid_q <= 1'b0;
			end
			if (load) begin
				hist_q    <= '0;
				seen_q    <= '0;
				sum_cnt_q <= '0;
				cnt_q     <= '0;
				best_q    <= '0;
				state_q   <= S_SUM;
			end else begin
				unique case (state_q)
					S_IDLE: begin
						if (accept && scan_req.func == FUNC_SCAN && scan_req.data_valid) begin
							hist_q  <= {hist_q[HIST_W-9:0], scan_req.data_byte};
							if (32'(seen_q) < PAT_BYTES) seen_q <= seen_q + LEN_W'(1);
							last_q  <= scan_req.last_byte;
							state_q <= S_EVAL;
						end
					end
					S_EVAL: begin
						state_q <= S_IDLE;
					end
					S_SUM: begin
						// The tail of the chain holds one cell's snapshot per cycle.
						cnt_q     <= cnt_q + 7'(chain[NUM_SIGS].hit);
						if (chain[NUM_SIGS].hit && chain[NUM_SIGS].thr > best_q) begin
							best_q <= chain[NUM_SIGS].thr;
						end
						sum_cnt_q <= sum_cnt_q + SIG_W'(1);
						if (32'(sum_cnt_q) == NUM_SIGS - 1) state_q <= S_DONE;
					end
					S_DONE: begin
						if (!result_valid_q || result_ready) begin
							global_q       <= global_next;
							files_q        <= files_next;
							hits_q         <= hits_next;
							result_q       <= '{match_count: cnt_q, buffer_threat: best_q,
								global_threat: global_next, files_scanned: files_next,
								threats_found: hits_next};
							result_valid_q <= 1'b1;
							state_q        <= S_IDLE;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// A scanned byte always gets its compare cycle before the next request.
	`WSS_ASSERT_NEXT(a_byte_then_eval, accept && scan_req.func == FUNC_SCAN && scan_req.data_valid, state_q == S_EVAL && !scan_ready)
	// The sticky threat maximum never falls.
	`WSS_ASSERT_NEXT(a_global_mono, 1'b1, global_q >= $past(global_q))
	// A result is only published from the final sequencer state.
	`WSS_ASSERT_NEXT(a_publish_from_done, !result_valid_q, !result_valid_q || $past(state_q) == S_DONE)
	// The tail counter never exceeds the number of cells inspected.
	`WSS_ASSERT_NOW(a_count_bound, state_q == S_SUM, 32'(cnt_q) <= 32'(sum_cnt_q))

endmodule
